@@ rtl/udp_ipv4_header_generator_assert.svh @@
// Assertion macros for the UDP/IPv4 header generator.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef UDP_IPV4_HEADER_GENERATOR_ASSERT_SVH
`define UDP_IPV4_HEADER_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDPGEN_ASSERT_NOW(label, cond_a, cond_c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_c)) else $error("udp header generator: check failed");

// The consequent must hold in the cycle after the antecedent.
`define UDPGEN_ASSERT_NEXT(label, cond_a, cond_c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_c)) else $error("udp header generator: check failed");

`endif

@@ rtl/udpgen_pkg.sv @@
// Shared types and constants of the UDP/IPv4 header generator.
// No dependencies; used by udpgen_hdr_pipe, udp_ipv4_header_generator and the testbench.
package udpgen_pkg;

    localparam int unsigned HDR_BYTES = 42;
    localparam int unsigned HDR_BITS  = HDR_BYTES * 8;
    localparam logic [5:0]  HDR_LAST  = 6'(HDR_BYTES - 1);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] IP_TTL_PROTO   = 16'hC811;
    localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [15:0] UDP_CSUM_NONE  = 16'h0000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEST_MAC       = 3'd0;
    localparam logic [2:0] CFG_SOURCE_MAC     = 3'd1;
    localparam logic [2:0] CFG_SOURCE_IP      = 3'd2;
    localparam logic [2:0] CFG_DEST_IP        = 3'd3;
    localparam logic [2:0] CFG_SOURCE_PORT    = 3'd4;
    localparam logic [2:0] CFG_MAIN_DEST_PORT = 3'd5;
    localparam logic [2:0] CFG_ALT_DEST_PORT  = 3'd6;

    // One header request as it arrives.
    typedef struct packed {
        logic [15:0] packet_ident;
        logic [15:0] frag_offset_bytes;
        logic [15:0] ip_payload_len;
        logic [2:0]  ip_flags;
        logic [15:0] udp_payload_len;
        logic        use_alt_port;
    } t_req;

    // Per-request header words once the lengths are formed.
    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] total_len;
        logic [15:0] flags_offset;
        logic [15:0] udp_len;
        logic        port_sel;
    } t_held;

    // Everything the serializer needs from one request.
    typedef struct packed {
        t_held       held;
        logic [15:0] checksum;
    } t_fields;

endpackage

@@ rtl/udpgen_hdr_pipe.sv @@
// Four-stage pipeline that forms the per-request header words and the IPv4 checksum.
// Depends on udpgen_pkg.
module udpgen_hdr_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  udpgen_pkg::t_req     i_req,
    input  logic [31:0]          i_source_ip,
    input  logic [31:0]          i_dest_ip,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output udpgen_pkg::t_fields  o_fields
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    udpgen_pkg::t_held r_h1, r_h2, r_h3, r_h4;
    udpgen_pkg::t_held n_h1;
    logic [17:0] r_sum_a, n_sum_a;
    logic [18:0] r_sum_b, n_sum_b;
    logic [19:0] sum_all;
    logic [16:0] r_fold, n_fold;
    logic [15:0] fold_two;
    logic [15:0] r_csum, n_csum;

    // A stage takes new data when it is empty or its content moves on.
    assign rdy4       = !r_v4 || i_out_ready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    always_comb begin
        n_h1.ident        = i_req.packet_ident;
        n_h1.total_len    = i_req.ip_payload_len + udpgen_pkg::IP_UDP_HDR_LEN;
        n_h1.flags_offset = {i_req.ip_flags, i_req.frag_offset_bytes[15:3]};
        n_h1.udp_len      = i_req.udp_payload_len + udpgen_pkg::UDP_HDR_LEN;
        n_h1.port_sel     = i_req.use_alt_port;
    end

    // Two partial sums: the per-request words and the static words.
    always_comb begin
        n_sum_a = 18'(udpgen_pkg::IP_VER_IHL_TOS) + 18'(r_h1.total_len)
                + 18'(r_h1.ident) + 18'(r_h1.flags_offset);
        n_sum_b = 19'(udpgen_pkg::IP_TTL_PROTO) + 19'(i_source_ip[31:16])
                + 19'(i_source_ip[15:0]) + 19'(i_dest_ip[31:16]) + 19'(i_dest_ip[15:0]);
    end

    // First carry fold; at most one more carry can remain afterwards.
    always_comb begin
        sum_all = 20'(r_sum_a) + 20'(r_sum_b);
        n_fold  = 17'(sum_all[15:0]) + 17'(sum_all[19:16]);
    end

    always_comb begin
        fold_two = r_fold[15:0] + 16'(r_fold[16]);
        n_csum   = ~fold_two;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_h1 <= n_h1;
        end
        if (rdy2) begin
            r_h2    <= r_h1;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
        if (rdy3) begin
            r_h3   <= r_h2;
            r_fold <= n_fold;
        end
        if (rdy4) begin
            r_h4   <= r_h3;
            r_csum <= n_csum;
        end
    end

    assign o_out_valid       = r_v4;
    assign o_fields.held     = r_h4;
    assign o_fields.checksum = r_csum;

endmodule

@@ rtl/udp_ipv4_header_generator.sv @@
// Top level of the Ethernet/IPv4/UDP header generator: registers, pipeline, byte serializer.
// Depends on udpgen_pkg, udpgen_hdr_pipe and udp_ipv4_header_generator_assert.svh.
//
// Usage: each transfer on the request channel (i_valid/o_ready) carries the
// per-packet fields and produces the 42-byte header of one UDP/IPv4 frame in
// wire order, one byte per transfer on the output channel (o_valid/i_ready).
// Each byte comes with its position 0..41 and a last flag on byte 41.
// Addresses, ports and MACs come from the configuration channel
// (i_cfg_valid/o_cfg_ready, register index and data), which is always ready
// and must only be written while no request is in flight.
// The first byte of a header is shown once its request has passed the four
// checksum stages in front of the serializer and has been loaded into it.
// The serializer emits one byte per cycle while the receiver is ready; the
// next header follows with no gap when it is waiting. The stages keep taking
// requests while the serializer is busy, so up to five are held in the block.
// Reset (synchronous, active low) empties the pipeline and the serializer and
// loads dest_mac and dest_ip with all ones, the other registers with zero.
// When the receiver stalls, the current byte stays on the outputs unchanged;
// the pipeline fills behind it and o_ready drops once every stage is full.
module udp_ipv4_header_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_packet_ident,
    input  logic [15:0] i_frag_offset_bytes,
    input  logic [15:0] i_ip_payload_len,
    input  logic [2:0]  i_ip_flags,
    input  logic [15:0] i_udp_payload_len,
    input  logic        i_use_alt_port,
    // Header byte channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_header_byte,
    output logic [5:0]  o_byte_index,
    output logic        o_last_byte,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

`include "udp_ipv4_header_generator_assert.svh"

    // Configuration registers.
    logic [47:0] r_dest_mac;
    logic [47:0] r_source_mac;
    logic [31:0] r_source_ip;
    logic [31:0] r_dest_ip;
    logic [15:0] r_source_port;
    logic [15:0] r_main_dest_port;
    logic [15:0] r_alt_dest_port;

    udpgen_pkg::t_req    req;
    udpgen_pkg::t_fields pipe_fields;
    logic                pipe_valid;
    logic                pipe_ready;

    // Serializer: the whole header sits in a shift register and leaves
    // through its top byte.
    logic                           r_ser_valid;
    logic [5:0]                     r_cnt;
    logic [udpgen_pkg::HDR_BITS-1:0] r_hdr;
    logic [udpgen_pkg::HDR_BITS-1:0] n_hdr;
    logic [15:0]                    dport;
    logic                           out_take;
    logic                           ser_last;
    logic                           ser_free;
    logic                           ser_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_mac       <= '1;
            r_source_mac     <= '0;
            r_source_ip      <= '0;
            r_dest_ip        <= '1;
            r_source_port    <= '0;
            r_main_dest_port <= '0;
            r_alt_dest_port  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                udpgen_pkg::CFG_DEST_MAC:       r_dest_mac       <= i_cfg_data;
                udpgen_pkg::CFG_SOURCE_MAC:     r_source_mac     <= i_cfg_data;
                udpgen_pkg::CFG_SOURCE_IP:      r_source_ip      <= i_cfg_data[31:0];
                udpgen_pkg::CFG_DEST_IP:        r_dest_ip        <= i_cfg_data[31:0];
                udpgen_pkg::CFG_SOURCE_PORT:    r_source_port    <= i_cfg_data[15:0];
                udpgen_pkg::CFG_MAIN_DEST_PORT: r_main_dest_port <= i_cfg_data[15:0];
                udpgen_pkg::CFG_ALT_DEST_PORT:  r_alt_dest_port  <= i_cfg_data[15:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    always_comb begin
        req.packet_ident      = i_packet_ident;
        req.frag_offset_bytes = i_frag_offset_bytes;
        req.ip_payload_len    = i_ip_payload_len;
        req.ip_flags          = i_ip_flags;
        req.udp_payload_len   = i_udp_payload_len;
        req.use_alt_port      = i_use_alt_port;
    end

    udpgen_hdr_pipe u_hdr_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_req       (req),
        .i_source_ip (r_source_ip),
        .i_dest_ip   (r_dest_ip),
        .o_out_valid (pipe_valid),
        .i_out_ready (pipe_ready),
        .o_fields    (pipe_fields)
    );

    // The serializer can take a new header when it is empty or when its last
    // byte is leaving in this cycle.
    assign out_take   = r_ser_valid && i_ready;
    assign ser_last   = (r_cnt == udpgen_pkg::HDR_LAST);
    assign ser_free   = !r_ser_valid || (out_take && ser_last);
    assign ser_load   = pipe_valid && ser_free;
    assign pipe_ready = ser_free;

    // Assemble the 42 header bytes, first wire byte in the top bits.
    always_comb begin
        dport = pipe_fields.held.port_sel ? r_alt_dest_port : r_main_dest_port;
        n_hdr = {r_dest_mac,
                 r_source_mac,
                 udpgen_pkg::ETHERTYPE_IPV4,
                 udpgen_pkg::IP_VER_IHL_TOS,
                 pipe_fields.held.total_len,
                 pipe_fields.held.ident,
                 pipe_fields.held.flags_offset,
                 udpgen_pkg::IP_TTL_PROTO,
                 pipe_fields.checksum,
                 r_source_ip,
                 r_dest_ip,
                 r_source_port,
                 dport,
                 pipe_fields.held.udp_len,
                 udpgen_pkg::UDP_CSUM_NONE};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
            r_cnt       <= '0;
        end else if (out_take) begin
            if (ser_last) begin
                r_ser_valid <= 1'b0;
                r_cnt       <= '0;
            end else begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_hdr <= n_hdr;
        end else if (out_take) begin
            r_hdr <= {r_hdr[udpgen_pkg::HDR_BITS-9:0], 8'h00};
        end
    end

    assign o_valid       = r_ser_valid;
    assign o_header_byte = r_hdr[udpgen_pkg::HDR_BITS-1 -: 8];
    assign o_byte_index  = r_cnt;
    assign o_last_byte   = ser_last;

    // The byte counter never runs past the last header byte.
    `UDPGEN_ASSERT_NOW(a_cnt_range, r_ser_valid, r_cnt <= udpgen_pkg::HDR_LAST)
    // A newly loaded header starts at its first byte.
    `UDPGEN_ASSERT_NEXT(a_load_starts, ser_load, r_ser_valid && (r_cnt == 6'd0))
    // After a byte that is not the last, the next byte of the same header follows.
    `UDPGEN_ASSERT_NEXT(a_index_steps, out_take && !ser_last,
        r_ser_valid && (r_cnt == 6'($past(r_cnt) + 6'd1)))

endmodule

@@ sim/udp_ipv4_header_generator_test.sv @@
// Self-checking testbench for the Ethernet/IPv4/UDP header generator.
// Depends on udpgen_pkg and the udp_ipv4_header_generator RTL only.
`timescale 1ns / 1ps

module udp_ipv4_header_generator_test;

    import udpgen_pkg::*;

    // The register file decodes indexes 0..6; a write to 7 must change nothing.
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    // Longest run of cycles without any transfer on any channel before the
    // run is declared hung. Sender gaps, receiver stalls and the closing
    // pause are all far shorter than this.
    localparam int unsigned STALL_LIMIT = 5000;

    // One header byte as it should appear on the output channel.
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] index;
        logic       last;
    } t_wire_byte;

    // Tracks the register contents, forms every header byte that an accepted
    // request must produce and checks the bytes as they come out.
    class header_byte_tracker;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] main_dest_port;
        logic [15:0] alt_dest_port;
        t_wire_byte  pending_bytes[$];
        int unsigned mismatches;

        function new();
            dest_mac       = '1;
            source_mac     = '0;
            source_ip      = '0;
            dest_ip        = '1;
            source_port    = '0;
            main_dest_port = '0;
            alt_dest_port  = '0;
            mismatches     = 0;
        endfunction

        // Registers keep only as many low bits of the data as they are wide.
        function void write_register(logic [2:0] index, logic [47:0] data);
            case (index)
                CFG_DEST_MAC:       dest_mac       = data;
                CFG_SOURCE_MAC:     source_mac     = data;
                CFG_SOURCE_IP:      source_ip      = data[31:0];
                CFG_DEST_IP:        dest_ip        = data[31:0];
                CFG_SOURCE_PORT:    source_port    = data[15:0];
                CFG_MAIN_DEST_PORT: main_dest_port = data[15:0];
                CFG_ALT_DEST_PORT:  alt_dest_port  = data[15:0];
                default: ;
            endcase
        endfunction

        function void add_header(t_req req);
            t_held               held;
            logic [31:0]         sum;
            logic [15:0]         checksum;
            logic [15:0]         dest_port;
            logic [HDR_BITS-1:0] frame;
            t_wire_byte          entry;

            // Both lengths wrap at 16 bits; the offset loses its low three bits.
            held.ident        = req.packet_ident;
            held.total_len    = req.ip_payload_len + IP_UDP_HDR_LEN;
            held.flags_offset = {req.ip_flags, req.frag_offset_bytes[15:3]};
            held.udp_len      = req.udp_payload_len + UDP_HDR_LEN;
            held.port_sel     = req.use_alt_port;

            sum = 32'(IP_VER_IHL_TOS) + 32'(held.total_len) + 32'(held.ident)
                + 32'(held.flags_offset) + 32'(IP_TTL_PROTO)
                + 32'(source_ip[31:16]) + 32'(source_ip[15:0])
                + 32'(dest_ip[31:16]) + 32'(dest_ip[15:0]);
            // Folding a carry can itself carry, so repeat until clean.
            while (sum[31:16] != 16'd0) begin
                sum = 32'(sum[15:0]) + 32'(sum[31:16]);
            end
            checksum  = ~sum[15:0];
            dest_port = held.port_sel ? alt_dest_port : main_dest_port;

            frame = {dest_mac, source_mac, ETHERTYPE_IPV4, IP_VER_IHL_TOS,
                     held.total_len, held.ident, held.flags_offset, IP_TTL_PROTO,
                     checksum, source_ip, dest_ip, source_port, dest_port,
                     held.udp_len, UDP_CSUM_NONE};

            for (int k = 0; k < HDR_BYTES; k++) begin
                entry.value = frame[HDR_BITS - 1 - 8 * k -: 8];
                entry.index = 6'(k);
                entry.last  = (k == HDR_BYTES - 1);
                pending_bytes.push_back(entry);
            end
        endfunction

        function void check_byte(logic [7:0] value, logic [5:0] index, logic last);
            t_wire_byte want;

            if (pending_bytes.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected header byte %02h index %0d last %0b",
                             value, index, last);
                end
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                if (value !== want.value || index !== want.index || last !== want.last) begin
                    if (mismatches < 10) begin
                        $display("header byte wrong: expected %02h index %0d last %0b, got %02h index %0d last %0b",
                                 want.value, want.index, want.last, value, index, last);
                    end
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_packet_ident = '0;
    logic [15:0] i_frag_offset_bytes = '0;
    logic [15:0] i_ip_payload_len = '0;
    logic [2:0]  i_ip_flags = '0;
    logic [15:0] i_udp_payload_len = '0;
    logic        i_use_alt_port = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_header_byte;
    logic [5:0]  o_byte_index;
    logic        o_last_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_DEST_MAC;
    logic [47:0] i_cfg_data = '0;

    header_byte_tracker headers = new();

    // Receiver pattern state: a mode picked every so often, plus the length
    // of a stall in progress.
    int unsigned rx_mode = 0;
    int unsigned rx_mode_cycles = 0;
    int unsigned rx_stall_left = 0;

    always #1 i_clk = ~i_clk;

    udp_ipv4_header_generator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_packet_ident      (i_packet_ident),
        .i_frag_offset_bytes (i_frag_offset_bytes),
        .i_ip_payload_len    (i_ip_payload_len),
        .i_ip_flags          (i_ip_flags),
        .i_udp_payload_len   (i_udp_payload_len),
        .i_use_alt_port      (i_use_alt_port),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_header_byte       (o_header_byte),
        .o_byte_index        (o_byte_index),
        .o_last_byte         (o_last_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Output side. Signals read right after the edge still hold the values
    // they had at the edge, so a transfer is seen exactly when it happens.
    // The receiver cycles through four behaviors: always ready, a coin toss
    // per cycle, mostly ready with occasional long stalls, and ready on average
    // one cycle in four. Stalls thus land on every byte position of a header.
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            headers.check_byte(o_header_byte, o_byte_index, o_last_byte);
        end
        if (rx_mode_cycles == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_cycles = $urandom_range(20, 150);
        end else begin
            rx_mode_cycles--;
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom);
                2: begin
                    if ($urandom_range(0, 15) == 0) begin
                        rx_stall_left = $urandom_range(1, 24);
                        i_ready <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Hang detection: counts cycles with no transfer on any channel.
    initial begin : watchdog
        int unsigned quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("udp_ipv4_header_generator: mismatch");
        $finish;
    end

    // Presents one request and holds it until the transfer. Valid is left
    // high so a following request goes out back to back; the caller lowers it.
    task automatic send_request(input t_req req);
        i_valid             <= 1'b1;
        i_packet_ident      <= req.packet_ident;
        i_frag_offset_bytes <= req.frag_offset_bytes;
        i_ip_payload_len    <= req.ip_payload_len;
        i_ip_flags          <= req.ip_flags;
        i_udp_payload_len   <= req.udp_payload_len;
        i_use_alt_port      <= req.use_alt_port;
        do @(posedge i_clk); while (!o_ready);
        headers.add_header(req);
    endtask

    // Sends a list of requests in bursts of random length. Some lists go out
    // with no gaps at all so the pipeline runs completely full.
    task automatic send_requests(input t_req reqs[$]);
        int unsigned burst_left;
        bit          gapless;

        gapless = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(1, 12);
        foreach (reqs[i]) begin
            send_request(reqs[i]);
            burst_left--;
            if (burst_left == 0 && i != reqs.size() - 1) begin
                burst_left = $urandom_range(1, 12);
                if (!gapless) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    // Register writes go out back to back; the caller lowers valid afterward.
    task automatic write_register(input logic [2:0] index, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        headers.write_register(index, data);
    endtask

    // Every register gets its own value; full 48-bit data also exercises the
    // masking of the narrower registers. A write to the unmapped index is
    // mixed in on request and must leave everything as it was.
    task automatic write_all_registers(input logic [47:0] values[7], input bit add_unmapped);
        write_register(CFG_DEST_MAC,       values[0]);
        write_register(CFG_SOURCE_MAC,     values[1]);
        if (add_unmapped) begin
            write_register(CFG_UNMAPPED, 48'({$urandom, $urandom}) | 48'h1);
        end
        write_register(CFG_SOURCE_IP,      values[2]);
        write_register(CFG_DEST_IP,        values[3]);
        write_register(CFG_SOURCE_PORT,    values[4]);
        write_register(CFG_MAIN_DEST_PORT, values[5]);
        write_register(CFG_ALT_DEST_PORT,  values[6]);
        i_cfg_valid <= 1'b0;
    endtask

    // Every request yields bytes, so once none are outstanding the block is
    // idle and safe to reconfigure.
    task automatic wait_for_headers();
        while (headers.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_req make_request(logic [15:0] ident, logic [15:0] offset,
                                          logic [15:0] ip_len, logic [2:0] flags,
                                          logic [15:0] udp_len, logic alt);
        t_req req;

        req.packet_ident      = ident;
        req.frag_offset_bytes = offset;
        req.ip_payload_len    = ip_len;
        req.ip_flags          = flags;
        req.udp_payload_len   = udp_len;
        req.use_alt_port      = alt;
        return req;
    endfunction

    // Lengths are drawn from typical frame sizes, the whole field, the legal
    // range, or the top of the field where the added header length wraps.
    function automatic t_req random_request();
        t_req req;

        req.packet_ident      = 16'($urandom);
        req.frag_offset_bytes = 16'($urandom);
        req.ip_flags          = 3'($urandom);
        req.use_alt_port      = 1'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                req.ip_payload_len  = 16'($urandom_range(0, 1500));
                req.udp_payload_len = 16'($urandom_range(0, 1500));
            end
            1: begin
                req.ip_payload_len  = 16'($urandom);
                req.udp_payload_len = 16'($urandom);
            end
            2: begin
                req.ip_payload_len  = 16'($urandom_range(65490, 65535));
                req.udp_payload_len = 16'($urandom_range(65510, 65535));
            end
            default: begin
                req.ip_payload_len  = 16'($urandom_range(0, 65507));
                req.udp_payload_len = 16'($urandom_range(0, 65527));
            end
        endcase
        return req;
    endfunction

    task automatic send_random_requests(input int unsigned count);
        t_req reqs[$];

        repeat (count) reqs.push_back(random_request());
        send_requests(reqs);
    endtask

    initial begin : stimulus
        t_req        directed[$];
        logic [47:0] values[7];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset register values.
        // Everything zero, then every field at its top value: both lengths wrap.
        directed.push_back(make_request(16'h0000, 16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0));
        directed.push_back(make_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1));
        // Largest legal payloads, then the first values where the lengths wrap to zero.
        directed.push_back(make_request(16'h1234, 16'h0008, 16'd65507, 3'd0, 16'd65527, 1'b0));
        directed.push_back(make_request(16'h8000, 16'h0010, 16'd65508, 3'd2, 16'd65528, 1'b1));
        // Unaligned offsets lose their low bits, then the top aligned one; each flag alone.
        directed.push_back(make_request(16'h0001, 16'h0007, 16'd100, 3'd1, 16'd92, 1'b0));
        directed.push_back(make_request(16'h0002, 16'h000F, 16'd200, 3'd2, 16'd192, 1'b1));
        directed.push_back(make_request(16'h0003, 16'h1235, 16'd1472, 3'd4, 16'd1472, 1'b0));
        directed.push_back(make_request(16'h0004, 16'hFFF8, 16'd1, 3'd0, 16'd1, 1'b1));
        // Checksum sum where the first carry fold carries once more.
        directed.push_back(make_request(16'hF2D3, 16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0));
        // Alternating bit patterns in both phases.
        directed.push_back(make_request(16'hAAAA, 16'h5555, 16'hAAAA, 3'd5, 16'h5555, 1'b0));
        directed.push_back(make_request(16'h5555, 16'hAAAA, 16'h5555, 3'd2, 16'hAAAA, 1'b1));
        send_requests(directed);
        wait_for_headers();

        // All registers zero, with a write to the unmapped index in between.
        foreach (values[i]) values[i] = '0;
        write_all_registers(values, 1'b1);
        send_requests(directed);
        send_random_requests(35);
        wait_for_headers();

        // All registers written with all ones: the widest values and masking.
        foreach (values[i]) values[i] = '1;
        write_all_registers(values, 1'b0);
        send_random_requests(40);
        wait_for_headers();

        // Random register contents between the phases.
        repeat (5) begin
            foreach (values[i]) values[i] = 48'({$urandom, $urandom});
            write_all_registers(values, $urandom_range(0, 1));
            send_random_requests(41);
            wait_for_headers();
        end

        // Give any stray byte a chance to show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (headers.mismatches == 0 && headers.pending() == 0) begin
            $display("udp_ipv4_header_generator: match");
        end else begin
            $display("udp_ipv4_header_generator: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/udpgen_pkg.sv
rtl/udpgen_hdr_pipe.sv
rtl/udp_ipv4_header_generator.sv
sim/udp_ipv4_header_generator_test.sv
